// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the spline evaluator checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRL_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("crl check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define CRL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("crl check failed: next-cycle implication");

`endif

// File: sv/crl_pkg.sv
// ---------------------------------------------------------------------------
// crl_pkg
// Widths, types and codes shared by the Catmull-Rom loop evaluator files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crl_pkg;

   localparam int COORD_W     = 32;
   localparam int POS_W       = 16;
   localparam int IDX_W       = 5;
   localparam int CNT_REG_W   = 6;
   localparam int MIN_POINTS  = 4;
   localparam int STAGES      = 9;

   // Horner intermediates stay below 2^36 in magnitude
   localparam int V_W         = 38;
   localparam int PROD_W      = V_W + POS_W + 1;

   localparam int REQ_DATA_W  = 120;
   localparam int RSP_DATA_W  = 96;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_EVAL   = 1'b1;

   typedef logic [2:0][COORD_W-1:0]  point_type;   // [0] x, [1] y, [2] z
   typedef logic signed [V_W-1:0]    wide_type;
   typedef logic signed [PROD_W-1:0] prod_type;

endpackage

`default_nettype wire

// File: sv/catmull_rom_loop_evaluator_core.sv
// Throughput: one item per cycle while the output is not stalled; write items
// give no result. Evaluations pass a 9-stage pipeline: point memory read,
// coefficients, three multiply/round pairs of the Horner chain, then final
// rounding and saturation.
// Reset clears pipeline valid bits and sets point_count to 4; the point
// memories are not cleared and hold garbage until written.
// ---------------------------------------------------------------------------
// catmull_rom_loop_evaluator_core
// Closed-loop uniform Catmull-Rom position evaluator over a point memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_loop_evaluator_core
   import crl_pkg::*;
#(
   parameter int MAX_POINTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: point_index[4:0], coord_x[36:5], coord_y[68:37], coord_z[100:69],
   //            loop_position[116:101], zero fill [119:117]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: opcode[0]
   input  wire logic [0:0]            req_tuser,
   // rsp_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CNT_REG_W-1:0]  csr_data
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam prod_type HALF   = prod_type'(1) <<< (POS_W - 1);
   localparam wide_type SAT_HI = wide_type'({1'b0, {(COORD_W-1){1'b1}}});
   localparam wide_type SAT_LO = -SAT_HI - wide_type'(1);

   // ---- request unpack ----
   logic              opcode;
   logic [IDX_W-1:0]  point_index;
   point_type         wr_pt;
   logic [POS_W-1:0]  loop_position;

   assign opcode        = req_tuser[0];
   assign point_index   = req_tdata[4:0];
   assign wr_pt[0]      = req_tdata[36:5];
   assign wr_pt[1]      = req_tdata[68:37];
   assign wr_pt[2]      = req_tdata[100:69];
   assign loop_position = req_tdata[116:101];

   // ---- point count register (held clamped) ----
   logic [CW-1:0] cnt_ff, cnt_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cnt_in = cnt_ff;
      if (csr_valid) begin
         if (32'(csr_data) < 32'(MIN_POINTS)) begin
            cnt_in = CW'(MIN_POINTS);
         end else if (32'(csr_data) > 32'(MAX_POINTS)) begin
            cnt_in = CW'(MAX_POINTS);
         end else begin
            cnt_in = CW'(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CW'(MIN_POINTS);
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // ---- pipeline flow control ----
   logic [STAGES:1] vld_ff, vld_in;
   logic [STAGES:1] en;
   logic            ev_acc, wr_acc, slot_ok;

   always_comb begin
      en[STAGES] = !vld_ff[STAGES] || rsp_tready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];
   assign slot_ok    = 32'(point_index) < 32'(MAX_POINTS);
   assign ev_acc     = req_tvalid && en[1] && (opcode == OP_EVAL);
   assign wr_acc     = req_tvalid && en[1] && (opcode == OP_WRITE) && slot_ok;

   always_comb begin
      vld_in = vld_ff;
      if (en[1]) begin
         vld_in[1] = ev_acc;
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---- segment and neighbor indexes ----
   logic [POS_W+CW-1:0] scaled;
   logic [CW-1:0]       seg;
   logic [POS_W-1:0]    u0;
   logic [CW:0]         nx1, nx2, ix0, ix2, ix3;
   logic [AW-1:0]       rd0, rd1, rd2, rd3, wr_addr;

   always_comb begin
      scaled = (POS_W+CW)'(loop_position) * (POS_W+CW)'(cnt_ff);
      seg    = scaled[POS_W+CW-1:POS_W];
      u0     = scaled[POS_W-1:0];
      nx1    = (CW+1)'(seg) + (CW+1)'(1);
      nx2    = (CW+1)'(seg) + (CW+1)'(2);
      ix0    = (seg == '0) ? ((CW+1)'(cnt_ff) - (CW+1)'(1))
                           : ((CW+1)'(seg) - (CW+1)'(1));
      ix2    = (nx1 >= (CW+1)'(cnt_ff)) ? (nx1 - (CW+1)'(cnt_ff)) : nx1;
      ix3    = (nx2 >= (CW+1)'(cnt_ff)) ? (nx2 - (CW+1)'(cnt_ff)) : nx2;
      rd0    = AW'(ix0);
      rd1    = AW'(seg);
      rd2    = AW'(ix2);
      rd3    = AW'(ix3);
      wr_addr = AW'(point_index);
   end

   // ---- point memories: identical copies, two read ports each ----
   point_type mem_a [MAX_POINTS];
   point_type mem_b [MAX_POINTS];

   point_type        p0_ff, p1_ff, p2_ff, p3_ff;
   logic [POS_W-1:0] u1_ff;

   always_ff @(posedge clock) begin
      if (wr_acc) begin
         mem_a[wr_addr] <= wr_pt;
         mem_b[wr_addr] <= wr_pt;
      end
      if (ev_acc) begin
         p0_ff <= mem_a[rd0];
         p1_ff <= mem_a[rd1];
         p2_ff <= mem_b[rd2];
         p3_ff <= mem_b[rd3];
         u1_ff <= u0;
      end
   end

   // ---- arithmetic helpers ----
   function automatic wide_type sx(input logic [COORD_W-1:0] p);
      return wide_type'($signed(p));
   endfunction

   function automatic prod_type mul_u(input wide_type v, input logic [POS_W-1:0] u);
      logic signed [POS_W:0] us;
      us = $signed({1'b0, u});
      return prod_type'(v) * prod_type'(us);
   endfunction

   // floor((m + 2^15) / 2^16) + k
   function automatic wide_type rnd_add(input prod_type m, input wide_type k);
      prod_type t;
      t = (m + HALF) >>> POS_W;
      return wide_type'(t) + k;
   endfunction

   function automatic logic [COORD_W-1:0] sat_half(input wide_type v);
      wide_type r;
      r = (v + wide_type'(1)) >>> 1;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[COORD_W-1:0];
   endfunction

   // ---- stage payloads ----
   wide_type         a2_ff [3], b2_ff [3], c2_ff [3], d2_ff [3];
   logic [POS_W-1:0] u2_ff, u3_ff, u4_ff, u5_ff, u6_ff;
   prod_type         m3_ff [3], m5_ff [3], m7_ff [3];
   wide_type         a3_ff [3], b3_ff [3], c3_ff [3];
   wide_type         h4_ff [3], a4_ff [3], b4_ff [3];
   wide_type         a5_ff [3], b5_ff [3];
   wide_type         h6_ff [3], a6_ff [3];
   wide_type         a7_ff [3];
   wide_type         h8_ff [3];
   point_type        out_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         u2_ff <= u1_ff;
         for (int ax = 0; ax < 3; ax++) begin
            a2_ff[ax] <= sx(p1_ff[ax]) + sx(p1_ff[ax]);
            b2_ff[ax] <= sx(p2_ff[ax]) - sx(p0_ff[ax]);
            c2_ff[ax] <= (sx(p0_ff[ax]) <<< 1) - ((sx(p1_ff[ax]) <<< 2) + sx(p1_ff[ax]))
                         + (sx(p2_ff[ax]) <<< 2) - sx(p3_ff[ax]);
            d2_ff[ax] <= ((sx(p1_ff[ax]) - sx(p2_ff[ax])) <<< 1)
                         + (sx(p1_ff[ax]) - sx(p2_ff[ax]))
                         + sx(p3_ff[ax]) - sx(p0_ff[ax]);
         end
      end
      if (en[3]) begin
         u3_ff <= u2_ff;
         for (int ax = 0; ax < 3; ax++) begin
            m3_ff[ax] <= mul_u(d2_ff[ax], u2_ff);
            a3_ff[ax] <= a2_ff[ax];
            b3_ff[ax] <= b2_ff[ax];
            c3_ff[ax] <= c2_ff[ax];
         end
      end
      if (en[4]) begin
         u4_ff <= u3_ff;
         for (int ax = 0; ax < 3; ax++) begin
            h4_ff[ax] <= rnd_add(m3_ff[ax], c3_ff[ax]);
            a4_ff[ax] <= a3_ff[ax];
            b4_ff[ax] <= b3_ff[ax];
         end
      end
      if (en[5]) begin
         u5_ff <= u4_ff;
         for (int ax = 0; ax < 3; ax++) begin
            m5_ff[ax] <= mul_u(h4_ff[ax], u4_ff);
            a5_ff[ax] <= a4_ff[ax];
            b5_ff[ax] <= b4_ff[ax];
         end
      end
      if (en[6]) begin
         u6_ff <= u5_ff;
         for (int ax = 0; ax < 3; ax++) begin
            h6_ff[ax] <= rnd_add(m5_ff[ax], b5_ff[ax]);
            a6_ff[ax] <= a5_ff[ax];
         end
      end
      if (en[7]) begin
         for (int ax = 0; ax < 3; ax++) begin
            m7_ff[ax] <= mul_u(h6_ff[ax], u6_ff);
            a7_ff[ax] <= a6_ff[ax];
         end
      end
      if (en[8]) begin
         for (int ax = 0; ax < 3; ax++) begin
            h8_ff[ax] <= rnd_add(m7_ff[ax], a7_ff[ax]);
         end
      end
      if (en[9]) begin
         for (int ax = 0; ax < 3; ax++) begin
            out_ff[ax] <= sat_half(h8_ff[ax]);
         end
      end
   end

   assign rsp_tvalid = vld_ff[STAGES];
   assign rsp_tdata  = out_ff;

endmodule

`default_nettype wire

// File: sv/crl_checker.sv
// ---------------------------------------------------------------------------
// crl_checker
// Port-level checks for the Catmull-Rom loop evaluator, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crl_checker
   import crl_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [0:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic eval_seen;
   logic rsp_stall;

   assign eval_seen = req_tvalid && req_tready && (req_tuser[0] == OP_EVAL);
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // pipeline comes up empty
   `CRL_ASSERT_IMPL(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)

   // input only backs up when the result side is stalled
   `CRL_ASSERT_IMPL(a_ready_stall, clock, reset, !req_tready, rsp_stall)

   // stalled result holds
   `CRL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // with the output draining every cycle, an evaluate shows up after the full pipe
   `CRL_ASSERT_NEXT(a_eval_latency, clock, reset, eval_seen ##1 rsp_tready [*8], rsp_tvalid)

endmodule

bind catmull_rom_loop_evaluator_core crl_checker u_crl_checker (.*);

`default_nettype wire

// File: tb/tb_catmull_rom_loop_evaluator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_catmull_rom_loop_evaluator_core
// Drives point writes and loop evaluations into the spline core with bursty
// input and a stalling output side. A bit-exact fixed-point model in the
// bench predicts each evaluated position the directed table does not give.
// The bench runs a short table of corner cases first, then random traffic
// under several point counts, also below and above the legal range.
// ---------------------------------------------------------------------------

module tb_catmull_rom_loop_evaluator_core;
   import crl_pkg::*;

   localparam int TABLE_DEPTH  = 32;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_WAIT  = STAGES + 6;
   localparam int PHASE_ITEMS  = 117;
   localparam int PRINT_CAP    = 200;

   localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;

   typedef struct packed {
      logic               op;
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [POS_W-1:0]   pos;
   } req_item_type;

   // want holds {z, y, x}, used only where known is set
   typedef struct packed {
      req_item_type          item;
      logic                  known;
      logic [RSP_DATA_W-1:0] want;
   } vector_type;

   localparam logic [CNT_REG_W-1:0] COUNT_PLAN [10] =
      '{6'd32, 6'd0, 6'd63, 6'd5, 6'd33, 6'd3, 6'd17, 6'd31, 6'd4, 6'd11};

   // point count stays at its reset value of 4 for this table
   localparam vector_type DIRECTED [17] = '{
      '{'{OP_WRITE, 5'd0, C_MIN, C_MAX, 32'h8000_0001, 16'h0}, 1'b0, 96'h0},
      '{'{OP_WRITE, 5'd1, C_MAX, C_MIN, 32'h7FFF_FFFE, 16'h0}, 1'b0, 96'h0},
      '{'{OP_WRITE, 5'd2, C_MAX, C_MIN, 32'h7FFF_FFFE, 16'h0}, 1'b0, 96'h0},
      '{'{OP_WRITE, 5'd3, C_MIN, C_MAX, 32'h8000_0001, 16'h0}, 1'b0, 96'h0},
      // zero fraction lands exactly on a control point
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'h0000}, 1'b1,
        {32'h8000_0001, C_MAX, C_MIN}},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'h4000}, 1'b1,
        {32'h7FFF_FFFE, C_MIN, C_MAX}},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'hC000}, 1'b1,
        {32'h8000_0001, C_MAX, C_MIN}},
      // overshoot between two extreme points saturates
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'h6000}, 1'b1,
        {C_MAX, C_MIN, C_MAX}},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'hFFFF}, 1'b0, 96'h0},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'h0001}, 1'b0, 96'h0},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'hA000}, 1'b0, 96'h0},
      '{'{OP_WRITE, 5'd31, 32'h0, 32'hFFFF_FFFF, 32'h1, 16'hFFFF}, 1'b0, 96'h0},
      '{'{OP_WRITE, 5'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h0}, 1'b0, 96'h0},
      // read of a slot right behind its write
      '{'{OP_EVAL, 5'd31, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h6000}, 1'b0, 96'h0},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'h8000}, 1'b1,
        {32'h0, 32'hFFFF_0000, 32'h0001_0000}},
      '{'{OP_WRITE, 5'd0, 32'h0, 32'h0, 32'h0, 16'h0}, 1'b0, 96'h0},
      '{'{OP_EVAL, 5'd0, 32'h0, 32'h0, 32'h0, 16'h2000}, 1'b0, 96'h0}
   };

   logic                  clock;
   logic                  reset        = 1'b1;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata    = '0;
   logic [0:0]            req_tuser    = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [CNT_REG_W-1:0]  csr_data     = '0;

   // bench copy of the point table and the count register
   logic [COORD_W-1:0]    loop_x [TABLE_DEPTH];
   logic [COORD_W-1:0]    loop_y [TABLE_DEPTH];
   logic [COORD_W-1:0]    loop_z [TABLE_DEPTH];
   logic [CNT_REG_W-1:0]  count_shadow = 6'd4;

   logic [RSP_DATA_W-1:0] pos_expected [$];
   logic [RSP_DATA_W-1:0] next_pos;
   int                    mismatch_count = 0;
   int                    idle_cycles    = 0;
   int                    burst_left     = 0;
   bit                    sender_steady  = 1'b0;
   logic [15:0]           ready_pattern  = 16'hFFFF;
   logic [31:0]           ready_step     = '0;

   catmull_rom_loop_evaluator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int loop_len();
      int n;
      n = int'(count_shadow);
      if (n < MIN_POINTS) n = MIN_POINTS;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
   endfunction

   // Horner evaluation with rounding after each step, then halved and saturated
   function automatic logic [COORD_W-1:0] spline_axis(input logic signed [COORD_W-1:0] p0,
                                                       input logic signed [COORD_W-1:0] p1,
                                                       input logic signed [COORD_W-1:0] p2,
                                                       input logic signed [COORD_W-1:0] p3,
                                                       input longint u);
      longint a, b, c, d, v;
      a = 2 * longint'(p1);
      b = longint'(p2) - longint'(p0);
      c = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
      d = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
      v = d;
      v = ((v * u + 64'sd32768) >>> 16) + c;
      v = ((v * u + 64'sd32768) >>> 16) + b;
      v = ((v * u + 64'sd32768) >>> 16) + a;
      v = (v + 1) >>> 1;
      if (v > longint'($signed(C_MAX))) v = longint'($signed(C_MAX));
      if (v < longint'($signed(C_MIN))) v = longint'($signed(C_MIN));
      return v[COORD_W-1:0];
   endfunction

   function automatic void track_loop_item(input req_item_type it, output logic has_pos,
                                           output logic [RSP_DATA_W-1:0] pos);
      int     n, scaled, seg, i0, i1, i2, i3;
      longint u;
      has_pos = 1'b0;
      pos     = '0;
      if (it.op == OP_WRITE) begin
         loop_x[it.idx] = it.x;
         loop_y[it.idx] = it.y;
         loop_z[it.idx] = it.z;
      end else begin
         n      = loop_len();
         scaled = int'(it.pos) * n;
         seg    = scaled >> 16;
         u      = longint'(scaled & 32'hFFFF);
         i1     = seg % n;
         i0     = (seg + n - 1) % n;
         i2     = (seg + 1) % n;
         i3     = (seg + 2) % n;
         pos = {spline_axis(loop_z[i0], loop_z[i1], loop_z[i2], loop_z[i3], u),
                spline_axis(loop_y[i0], loop_y[i1], loop_y[i2], loop_y[i3], u),
                spline_axis(loop_x[i0], loop_x[i1], loop_x[i2], loop_x[i3], u)};
         has_pos = 1'b1;
      end
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         3, 4, 5: return $urandom;
         default: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      endcase
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int           n;
      n      = loop_len();
      it.op  = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_EVAL;
      it.idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      it.x   = rand_coord();
      it.y   = rand_coord();
      it.z   = rand_coord();
      case ($urandom_range(0, 9))
         0:       it.pos = '0;
         1:       it.pos = '1;
         // just past a segment boundary
         2, 3:    it.pos = POS_W'((($urandom_range(0, n - 1) << 16) + n - 1) / n);
         default: it.pos = POS_W'($urandom);
      endcase
      return it;
   endfunction

   task automatic report_mismatch(input string what, input logic [COORD_W-1:0] got,
                                  input logic [COORD_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic send(input req_item_type it, input logic known,
                       input logic [RSP_DATA_W-1:0] want);
      int                    gap;
      logic                  has_pos;
      logic [RSP_DATA_W-1:0] pos;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {3'b000, it.pos, it.z, it.y, it.x, it.idx};
      do @(posedge clock); while (!req_tready);
      track_loop_item(it, has_pos, pos);
      if (has_pos) pos_expected = {pos_expected, (known ? want : pos)};
   endtask

   // always advances at least one clock so valid never toggles twice in a step
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pos_expected.size() != 0);
   endtask

   task automatic set_point_count(input logic [CNT_REG_W-1:0] value);
      drain_results();
      // write transactions give no result, so the drain above does not wait on them
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_shadow = value;
   endtask

   // receiver ready follows a 16-bit pattern, reshuffled whenever the step counter's low six bits wrap
   always @(posedge clock) begin
      ready_step <= ready_step + 1;
      if (ready_step[5:0] == 6'd63)
         ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                      : (16'($urandom) | 16'h0001);
      rsp_tready <= ready_pattern[ready_step[3:0]];
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pos_expected.size() == 0) begin
            report_mismatch("unexpected result, pos_x", rsp_tdata[31:0], 'x);
         end else begin
            next_pos = pos_expected.pop_front();
            if (rsp_tdata[31:0] !== next_pos[31:0])
               report_mismatch("pos_x", rsp_tdata[31:0], next_pos[31:0]);
            if (rsp_tdata[63:32] !== next_pos[63:32])
               report_mismatch("pos_y", rsp_tdata[63:32], next_pos[63:32]);
            if (rsp_tdata[95:64] !== next_pos[95:64])
               report_mismatch("pos_z", rsp_tdata[95:64], next_pos[95:64]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TIMEOUT: no transaction for %0d cycles", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int           row, ph, n;
      req_item_type it;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < 17; row++)
         send(DIRECTED[row].item, DIRECTED[row].known, DIRECTED[row].want);

      // fill every slot so that any later count only reads written points
      for (n = 0; n < TABLE_DEPTH; n++) begin
         it     = random_item();
         it.op  = OP_WRITE;
         it.idx = IDX_W'(n);
         send(it, 1'b0, '0);
      end

      for (ph = 0; ph < 10; ph++) begin
         set_point_count(COUNT_PLAN[ph]);
         sender_steady = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 149) == 0) drain_results();
            send(random_item(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
